[rtl/vertex_scale_normal_correct_top_assert.svh]
// Assertion macros used by the vertex scale RTL.
`ifndef VERTEX_SCALE_NORMAL_CORRECT_TOP_ASSERT_SVH
`define VERTEX_SCALE_NORMAL_CORRECT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSNC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VSNC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vsnc_pkg.sv]
`timescale 1ns / 1ps

package vsnc_pkg;

    localparam int NUM_AXES = 3;
    localparam int NUM_TAN  = 4;
    localparam int IN_W     = 384;
    localparam int OUT_W    = 344;
    localparam int NRM_W    = 18;

    localparam logic [1:0] CFG_SCALE_X = 2'd0;
    localparam logic [1:0] CFG_SCALE_Y = 2'd1;
    localparam logic [1:0] CFG_SCALE_Z = 2'd2;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [3:0][31:0] tan;
        logic [63:0]      tex;
    } pay_t;

    typedef enum logic [1:0] {
        REC_IDLE,
        REC_RUN,
        REC_DONE
    } rec_state_t;

endpackage

[rtl/vertex_scale_normal_correct_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Ports                          Contents
// config    in         cfg_we, cfg_addr, cfg_wdata    scale_x, scale_y, scale_z
// vertex    in         s_tvalid, s_tready, s_tdata    one vertex per item
// result    out        m_tvalid, m_tready, m_tdata,   one transformed vertex per item
//                      m_tuser
// One item enters per cycle while the output is not held and no reciprocal update runs; the
// pipeline holds the 32-step square root pipeline and the FRAC_BITS + 1 step normal divider pipeline.
// A write to a scale register starts a bit-serial reciprocal unit, and no item is accepted
// while it runs; reset loads the reciprocals directly.
// Reset is synchronous and active low, clears the valid bits and sets the scales to one.
// When the output holds an item that is not taken, the whole pipeline holds.

module vertex_scale_normal_correct_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [31:0]                cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tan_x, tan_y, tan_z, tan_w, tex_u, tex_v
    input  logic [vsnc_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z, out_tan_x,
    // out_tan_y, out_tan_z, out_tan_w, out_tex_packed, two zero pad bits
    output logic [vsnc_pkg::OUT_W-1:0] m_tdata,
    // zero_normal
    output logic [0:0]                 m_tuser
);

    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] MIN64 = -64'sd2147483648;
    localparam logic [31:0] SMAX = 32'h7FFFFFFF;
    localparam logic [31:0] SMIN = 32'h80000000;
    localparam int RQW = 2 * FRAC_BITS + 1;
    localparam int RCW = $clog2(RQW);
    localparam int DQW = FRAC_BITS + 1;
    localparam int NSQ = 32;
    localparam int DIV0 = 6 + NSQ;
    localparam int NSTG = DIV0 + DQW + 1;
    localparam int OUT_IDX = NSTG - 1;
    localparam int NW = (DQW + 1 > vsnc_pkg::NRM_W) ? DQW + 1 : vsnc_pkg::NRM_W;

    function automatic logic [31:0] fx_round(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [63:0] sh;
        t = p + RND;
        sh = t >>> FRAC_BITS;
        if (sh > MAX64) begin
            return SMAX;
        end else if (sh < MIN64) begin
            return SMIN;
        end
        return sh[31:0];
    endfunction

    // Configuration and reciprocal unit
    logic signed [31:0]    scale_reg [3];
    logic [31:0]           recip_reg [3];
    logic [31:0]           recip_next [3];
    logic [31:0]           dvs [3];
    logic [31:0]           rem_reg [3];
    logic [31:0]           rem_next [3];
    logic [RQW-1:0]        quo_reg [3];
    logic [RQW-1:0]        quo_next [3];
    logic [32:0]           rsh [3];
    logic [63:0]           q64 [3];
    logic [RCW-1:0]        cnt_reg;
    vsnc_pkg::rec_state_t  rec_state_reg;
    vsnc_pkg::rec_state_t  rec_state_next;
    logic                  rec_start;
    logic                  rec_busy;
    logic                  rec_load;
    logic                  rec_step;
    logic                  rec_fin;

    assign rec_start = cfg_we && (cfg_addr == vsnc_pkg::CFG_SCALE_X
                                  || cfg_addr == vsnc_pkg::CFG_SCALE_Y
                                  || cfg_addr == vsnc_pkg::CFG_SCALE_Z);

    always_comb begin
        rec_state_next = rec_state_reg;
        unique case (rec_state_reg)
            vsnc_pkg::REC_IDLE: begin
                rec_state_next = vsnc_pkg::REC_IDLE;
            end
            vsnc_pkg::REC_RUN: begin
                if (cnt_reg == '0) begin
                    rec_state_next = vsnc_pkg::REC_DONE;
                end
            end
            vsnc_pkg::REC_DONE: begin
                rec_state_next = vsnc_pkg::REC_IDLE;
            end
            default: begin
                rec_state_next = vsnc_pkg::REC_IDLE;
            end
        endcase
        if (rec_start) begin
            rec_state_next = vsnc_pkg::REC_RUN;
        end
    end

    always_comb begin
        rec_busy = 1'b0;
        rec_step = 1'b0;
        rec_fin  = 1'b0;
        rec_load = rec_start;
        unique case (rec_state_reg)
            vsnc_pkg::REC_IDLE: begin
                rec_busy = 1'b0;
            end
            vsnc_pkg::REC_RUN: begin
                rec_busy = 1'b1;
                rec_step = 1'b1;
            end
            vsnc_pkg::REC_DONE: begin
                rec_busy = 1'b1;
                rec_fin  = 1'b1;
            end
            default: begin
                rec_busy = 1'b1;
            end
        endcase
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            dvs[a] = scale_reg[a][31] ? 32'(-scale_reg[a]) : scale_reg[a];
            rsh[a] = {rem_reg[a], cnt_reg == RCW'(2 * FRAC_BITS)};
            if (rsh[a] >= {1'b0, dvs[a]}) begin
                rem_next[a] = 32'(rsh[a] - {1'b0, dvs[a]});
                quo_next[a] = {quo_reg[a][RQW-2:0], 1'b1};
            end else begin
                rem_next[a] = rsh[a][31:0];
                quo_next[a] = {quo_reg[a][RQW-2:0], 1'b0};
            end
            q64[a] = 64'(quo_reg[a]);
            if (dvs[a] == '0) begin
                recip_next[a] = SMAX;
            end else if (!scale_reg[a][31]) begin
                recip_next[a] = (q64[a] > 64'h7FFFFFFF) ? SMAX : q64[a][31:0];
            end else begin
                recip_next[a] = (q64[a] > 64'h80000000) ? SMIN : 32'(-q64[a]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_state_reg <= vsnc_pkg::REC_IDLE;
            for (int a = 0; a < 3; a++) begin
                scale_reg[a] <= ONE;
                recip_reg[a] <= ONE;
            end
        end else begin
            rec_state_reg <= rec_state_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    vsnc_pkg::CFG_SCALE_X: scale_reg[0] <= cfg_wdata;
                    vsnc_pkg::CFG_SCALE_Y: scale_reg[1] <= cfg_wdata;
                    vsnc_pkg::CFG_SCALE_Z: scale_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (rec_fin) begin
                for (int a = 0; a < 3; a++) begin
                    recip_reg[a] <= recip_next[a];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_load) begin
            cnt_reg <= RCW'(2 * FRAC_BITS);
            for (int a = 0; a < 3; a++) begin
                rem_reg[a] <= '0;
                quo_reg[a] <= '0;
            end
        end else if (rec_step) begin
            cnt_reg <= cnt_reg - 1'b1;
            for (int a = 0; a < 3; a++) begin
                rem_reg[a] <= rem_next[a];
                quo_reg[a] <= quo_next[a];
            end
        end
    end

    logic unit_mode;
    logic uni_mode;

    assign unit_mode = scale_reg[0] == ONE && scale_reg[1] == ONE && scale_reg[2] == ONE;
    assign uni_mode  = scale_reg[0] == scale_reg[1] && scale_reg[1] == scale_reg[2];

    // Pipeline control
    logic [NSTG-1:0] vld_reg;
    logic            en;
    logic            in_ok;

    assign en       = !vld_reg[OUT_IDX] || m_tready;
    assign s_tready = en && !rec_busy;
    assign in_ok    = s_tvalid && s_tready;
    assign m_tvalid = vld_reg[OUT_IDX];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_ok};
        end
    end

    // Datapath
    logic signed [31:0]  in_pos [3];
    logic signed [31:0]  in_nrm [3];
    logic signed [31:0]  in_tan [3];
    vsnc_pkg::pay_t      pay_in;
    vsnc_pkg::pay_t      pay_reg [NSTG];
    vsnc_pkg::pay_t      st2_pay;

    logic signed [63:0]  prod_pos_reg [3];
    logic signed [63:0]  prod_nrm_reg [3];
    logic signed [63:0]  prod_tan_reg [3];
    logic signed [31:0]  nrm1_reg [3];
    logic signed [31:0]  nrm2_next [3];
    logic signed [31:0]  nrm2_reg [3];
    logic [31:0]         mag3 [3];
    logic [31:0]         max3_next;
    logic [31:0]         max3_reg;
    logic signed [31:0]  nrm3_reg [3];
    logic [4:0]          k4;
    logic signed [32:0]  c4_next [3];
    logic signed [32:0]  c4_reg [3];
    logic                z4_reg;
    logic signed [65:0]  p5 [3];
    logic [63:0]         sq5_reg [3];
    logic signed [32:0]  c5_reg [3];
    logic                z5_reg;
    logic [63:0]         sum6_reg;
    logic signed [32:0]  c6_reg [3];
    logic                z6_reg;

    logic [63:0]         sx_reg [NSQ];
    logic [63:0]         sr_reg [NSQ];
    logic [63:0]         sx_next [NSQ];
    logic [63:0]         sr_next [NSQ];
    logic [63:0]         sx_in [NSQ];
    logic [63:0]         sr_in [NSQ];
    logic [63:0]         s_tmp [NSQ];
    logic signed [32:0]  sc_reg [NSQ][3];
    logic                sz_reg [NSQ];

    logic [31:0]         dm [3];
    logic [31:0]         dl_reg [DQW];
    logic [31:0]         dr_reg [DQW][3];
    logic [31:0]         dr_next [DQW][3];
    logic [DQW-1:0]      dq_reg [DQW][3];
    logic [DQW-1:0]      dq_next [DQW][3];
    logic                dn_reg [DQW][3];
    logic                dz_reg [DQW];
    logic [31:0]         d_rin [DQW][3];
    logic                d_bin [DQW][3];
    logic [31:0]         d_lin [DQW];
    logic [DQW-1:0]      d_qin [DQW][3];
    logic [32:0]         d_rs [DQW][3];

    logic [NW-1:0]       qe [3];
    logic [17:0]         onrm_next [3];
    logic [17:0]         onrm_reg [3];
    logic                oz_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            in_pos[a]      = s_tdata[32*a +: 32];
            in_nrm[a]      = s_tdata[96 + 32*a +: 32];
            in_tan[a]      = s_tdata[192 + 32*a +: 32];
            pay_in.pos[a]  = s_tdata[32*a +: 32];
        end
        for (int a = 0; a < vsnc_pkg::NUM_TAN; a++) begin
            pay_in.tan[a] = s_tdata[192 + 32*a +: 32];
        end
        pay_in.tex = {s_tdata[351:320], s_tdata[383:352]};
    end

    always_comb begin
        st2_pay = pay_reg[0];
        for (int a = 0; a < 3; a++) begin
            if (!unit_mode) begin
                st2_pay.pos[a] = fx_round(prod_pos_reg[a]);
            end
            if (uni_mode) begin
                nrm2_next[a] = nrm1_reg[a];
            end else begin
                nrm2_next[a]   = fx_round(prod_nrm_reg[a]);
                st2_pay.tan[a] = fx_round(prod_tan_reg[a]);
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag3[a] = nrm2_reg[a][31] ? 32'(-nrm2_reg[a]) : nrm2_reg[a];
        end
        max3_next = mag3[0];
        if (mag3[1] > max3_next) begin
            max3_next = mag3[1];
        end
        if (mag3[2] > max3_next) begin
            max3_next = mag3[2];
        end
    end

    always_comb begin
        k4 = '0;
        for (int b = 0; b < 32; b++) begin
            if (max3_reg[b]) begin
                k4 = (b >= 30) ? 5'd0 : 5'(30 - b);
            end
        end
        for (int a = 0; a < 3; a++) begin
            c4_next[a] = 33'(nrm3_reg[a]) <<< k4;
            p5[a]      = c4_reg[a] * c4_reg[a];
        end
    end

    always_comb begin
        for (int j = 0; j < NSQ; j++) begin
            sx_in[j] = (j == 0) ? sum6_reg : sx_reg[(j == 0) ? 0 : j - 1];
            sr_in[j] = (j == 0) ? 64'd0 : sr_reg[(j == 0) ? 0 : j - 1];
            s_tmp[j] = sr_in[j] + (64'd1 << (62 - 2 * j));
            if (sx_in[j] >= s_tmp[j]) begin
                sx_next[j] = sx_in[j] - s_tmp[j];
                sr_next[j] = (sr_in[j] >> 1) + (64'd1 << (62 - 2 * j));
            end else begin
                sx_next[j] = sx_in[j];
                sr_next[j] = sr_in[j] >> 1;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            dm[a] = sc_reg[NSQ-1][a][32] ? 32'(-sc_reg[NSQ-1][a]) : sc_reg[NSQ-1][a][31:0];
        end
        for (int j = 0; j < DQW; j++) begin
            d_lin[j] = (j == 0) ? sr_reg[NSQ-1][31:0] : dl_reg[(j == 0) ? 0 : j - 1];
            for (int a = 0; a < 3; a++) begin
                d_rin[j][a] = (j == 0) ? (dm[a] >> 1) : dr_reg[(j == 0) ? 0 : j - 1][a];
                d_bin[j][a] = (j == 0) ? dm[a][0] : 1'b0;
                d_qin[j][a] = (j == 0) ? '0 : dq_reg[(j == 0) ? 0 : j - 1][a];
                d_rs[j][a]  = {d_rin[j][a], d_bin[j][a]};
                if (d_rs[j][a] >= {1'b0, d_lin[j]}) begin
                    dr_next[j][a] = 32'(d_rs[j][a] - {1'b0, d_lin[j]});
                    dq_next[j][a] = {d_qin[j][a][DQW-2:0], 1'b1};
                end else begin
                    dr_next[j][a] = d_rs[j][a][31:0];
                    dq_next[j][a] = {d_qin[j][a][DQW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            qe[a] = NW'(dq_reg[DQW-1][a]);
            if (dn_reg[DQW-1][a]) begin
                qe[a] = -qe[a];
            end
            onrm_next[a] = dz_reg[DQW-1] ? 18'd0 : qe[a][17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg[0] <= pay_in;
            for (int i = 2; i < NSTG; i++) begin
                pay_reg[i] <= pay_reg[i-1];
            end
            pay_reg[1] <= st2_pay;
            for (int a = 0; a < 3; a++) begin
                prod_pos_reg[a] <= in_pos[a] * $signed(scale_reg[a]);
                prod_nrm_reg[a] <= in_nrm[a] * $signed(recip_reg[a]);
                prod_tan_reg[a] <= in_tan[a] * $signed(recip_reg[a]);
                nrm1_reg[a]     <= in_nrm[a];
                nrm2_reg[a]     <= nrm2_next[a];
                nrm3_reg[a]     <= nrm2_reg[a];
                c4_reg[a]       <= c4_next[a];
                sq5_reg[a]      <= p5[a][63:0];
                c5_reg[a]       <= c4_reg[a];
                c6_reg[a]       <= c5_reg[a];
                onrm_reg[a]     <= onrm_next[a];
            end
            max3_reg <= max3_next;
            z4_reg   <= max3_reg == '0;
            z5_reg   <= z4_reg;
            sum6_reg <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            z6_reg   <= z5_reg;
            for (int j = 0; j < NSQ; j++) begin
                sx_reg[j] <= sx_next[j];
                sr_reg[j] <= sr_next[j];
                sz_reg[j] <= (j == 0) ? z6_reg : sz_reg[(j == 0) ? 0 : j - 1];
                for (int a = 0; a < 3; a++) begin
                    sc_reg[j][a] <= (j == 0) ? c6_reg[a] : sc_reg[(j == 0) ? 0 : j - 1][a];
                end
            end
            for (int j = 0; j < DQW; j++) begin
                dl_reg[j] <= d_lin[j];
                dz_reg[j] <= (j == 0) ? sz_reg[NSQ-1] : dz_reg[(j == 0) ? 0 : j - 1];
                for (int a = 0; a < 3; a++) begin
                    dr_reg[j][a] <= dr_next[j][a];
                    dq_reg[j][a] <= dq_next[j][a];
                    dn_reg[j][a] <= (j == 0) ? sc_reg[NSQ-1][a][32]
                                             : dn_reg[(j == 0) ? 0 : j - 1][a];
                end
            end
            oz_reg <= dz_reg[DQW-1];
        end
    end

    assign m_tdata = {2'b00, pay_reg[OUT_IDX].tex,
                      pay_reg[OUT_IDX].tan[3], pay_reg[OUT_IDX].tan[2],
                      pay_reg[OUT_IDX].tan[1], pay_reg[OUT_IDX].tan[0],
                      onrm_reg[2], onrm_reg[1], onrm_reg[0],
                      pay_reg[OUT_IDX].pos[2], pay_reg[OUT_IDX].pos[1],
                      pay_reg[OUT_IDX].pos[0]};
    assign m_tuser = oz_reg;

`include "vertex_scale_normal_correct_top_assert.svh"

    `VSNC_ASSERT_NEXT(a_cfg_holds_input, aclk, aresetn, rec_start, !s_tready, "item accepted during reciprocal update")
    `VSNC_ASSERT_NEXT(a_valid_shift, aclk, aresetn, en, vld_reg[NSTG-1:1] == $past(vld_reg[NSTG-2:0]), "valid bits lost in pipeline")
    `VSNC_ASSERT_SAME(a_zero_normal, aclk, aresetn, m_tvalid && m_tuser[0], onrm_reg[0] == '0 && onrm_reg[1] == '0 && onrm_reg[2] == '0, "zero normal flag with nonzero normal")

endmodule

[tb/sv/tb_vertex_scale_normal_correct_top.sv]
`timescale 1ns / 1ps

module tb_vertex_scale_normal_correct_top;

    localparam longint ONE = 64'sd65536;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [63:0]      tex;
        logic [3:0][31:0] tan;
        logic [2:0][17:0] nrm;
        logic [2:0][31:0] pos;
        logic             zn;
    } vtx_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_addr = vsnc_pkg::CFG_SCALE_X;
    logic [31:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [vsnc_pkg::IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [vsnc_pkg::OUT_W-1:0] m_tdata;
    logic [0:0] m_tuser;

    vertex_scale_normal_correct_top dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    longint scl [3];
    logic [vsnc_pkg::IN_W-1:0] vtx_pending [$];
    vtx_out_t vtx_expected [$];
    logic [vsnc_pkg::IN_W-1:0] vtx_cur;
    bit quiet = 1'b0;
    int in_gap = 0, out_gap = 0, hold_left = 0;
    int n_in = 0, n_out = 0, n_zero = 0, errors = 0, cycles = 0;
    bit held = 1'b0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return sat32((a * b + 64'sd32768) >>> 16);
    endfunction

    function automatic longint qrecip(longint s);
        if (s == 0) return 64'sd2147483647;
        return sat32((64'sd1 <<< 32) / s);
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic vtx_out_t scale_vertex(logic [vsnc_pkg::IN_W-1:0] d);
        vtx_out_t o;
        longint p [3], n [3], t [4];
        longint unsigned m, sum, len;
        int k;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'(signed'(d[32*i +: 32]));
            n[i] = longint'(signed'(d[32*(3+i) +: 32]));
        end
        for (int i = 0; i < 4; i++) t[i] = longint'(signed'(d[32*(6+i) +: 32]));
        if (!(scl[0] == ONE && scl[1] == ONE && scl[2] == ONE)) begin
            for (int i = 0; i < 3; i++) p[i] = qmul(p[i], scl[i]);
            if (!(scl[0] == scl[1] && scl[1] == scl[2])) begin
                for (int i = 0; i < 3; i++) begin
                    n[i] = qmul(n[i], qrecip(scl[i]));
                    t[i] = qmul(t[i], qrecip(scl[i]));
                end
            end
        end
        m = absval(n[0]);
        if (absval(n[1]) > m) m = absval(n[1]);
        if (absval(n[2]) > m) m = absval(n[2]);
        o.zn = (m == 0);
        if (m == 0) begin
            for (int i = 0; i < 3; i++) n[i] = 0;
        end else begin
            k = 0;
            while (m < (64'd1 << 30)) begin
                m = m << 1;
                k++;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                n[i] = n[i] * (64'sd1 <<< k);
                sum = sum + longint'(n[i] * n[i]);
            end
            len = root64(sum);
            for (int i = 0; i < 3; i++) n[i] = (n[i] * ONE) / longint'(len);
        end
        for (int i = 0; i < 3; i++) begin
            o.pos[i] = p[i][31:0];
            o.nrm[i] = n[i][17:0];
        end
        for (int i = 0; i < 4; i++) o.tan[i] = t[i][31:0];
        o.tex = {d[32*10 +: 32], d[32*11 +: 32]};
        return o;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("ERROR result %0d field %s: got %h, expected %h", n_out, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                vtx_expected.insert(vtx_expected.size(), scale_vertex(vtx_cur));
                n_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (vtx_pending.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        in_gap = $urandom_range(0, 6);
                        s_tvalid <= 1'b0;
                    end else begin
                        vtx_cur = vtx_pending.pop_front();
                        s_tdata <= vtx_cur;
                        s_tvalid <= 1'b1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        vtx_out_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[vsnc_pkg::OUT_W-3:0], m_tuser[0]};
                if (vtx_expected.size() == 0) begin
                    report("unexpected", got.tex, '0);
                end else begin
                    want = vtx_expected.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (got.pos[i] !== want.pos[i])
                            report($sformatf("out_pos[%0d]", i), got.pos[i], want.pos[i]);
                        if (got.nrm[i] !== want.nrm[i])
                            report($sformatf("out_nrm[%0d]", i), got.nrm[i], want.nrm[i]);
                    end
                    for (int i = 0; i < 4; i++)
                        if (got.tan[i] !== want.tan[i])
                            report($sformatf("out_tan[%0d]", i), got.tan[i], want.tan[i]);
                    if (got.tex !== want.tex) report("out_tex_packed", got.tex, want.tex);
                    if (got.zn !== want.zn) report("zero_normal", got.zn, want.zn);
                    if (want.zn) n_zero++;
                end
                n_out++;
                if (n_out == 150 && !held) begin
                    held = 1'b1;
                    hold_left = 300;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_gap = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL vertex_scale_normal_correct_top");
            $finish;
        end
    end

    function automatic logic [31:0] rand_field();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 511) - 256;
            3: v = $urandom_range(0, 4 * 65536) - 2 * 65536;
            4: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h0000_0001;
                    default: v = 32'h0;
                endcase
            end
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    function automatic logic [vsnc_pkg::IN_W-1:0] rand_vertex();
        logic [vsnc_pkg::IN_W-1:0] d;
        for (int i = 0; i < 12; i++) d[32*i +: 32] = rand_field();
        if ($urandom_range(0, 19) == 0) d[32*3 +: 96] = '0;
        return d;
    endfunction

    function automatic logic [vsnc_pkg::IN_W-1:0] make_vertex(logic [31:0] p, logic [31:0] n,
                                                              logic [31:0] t);
        logic [vsnc_pkg::IN_W-1:0] d;
        for (int i = 0; i < 3; i++) begin
            d[32*i +: 32] = p;
            d[32*(3+i) +: 32] = (i == 0) ? n : ~n;
            d[32*(6+i) +: 32] = t;
        end
        d[32*9 +: 32] = ~t;
        d[32*10 +: 32] = p;
        d[32*11 +: 32] = ~p;
        return d;
    endfunction

    task automatic add_vertex(logic [vsnc_pkg::IN_W-1:0] d);
        vtx_pending.insert(vtx_pending.size(), d);
    endtask

    task automatic set_scales(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic [31:0] v [3];
        logic [1:0] idx [3];
        v = '{x, y, z};
        idx = '{vsnc_pkg::CFG_SCALE_X, vsnc_pkg::CFG_SCALE_Y, vsnc_pkg::CFG_SCALE_Z};
        for (int i = 0; i < 3; i++) begin
            @(posedge aclk);
            cfg_we <= 1'b1;
            cfg_addr <= idx[i];
            cfg_wdata <= v[i];
            scl[i] = longint'(signed'(v[i]));
            @(posedge aclk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic drain();
        while (vtx_pending.size() > 0 || s_tvalid || vtx_expected.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic directed_set();
        add_vertex(make_vertex(32'h0, 32'h0, 32'h0));
        add_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        add_vertex(make_vertex(32'h0001_0000, 32'h0000_0001, 32'hFFFF_0000));
        add_vertex(make_vertex(32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001));
        add_vertex(make_vertex(32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000));
    endtask

    initial begin
        logic [31:0] r;
        for (int i = 0; i < 3; i++) scl[i] = ONE;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        directed_set();
        for (int i = 0; i < 300; i++) add_vertex(rand_vertex());
        drain();

        set_scales(32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        directed_set();
        for (int i = 0; i < 300; i++) add_vertex(rand_vertex());
        drain();

        set_scales(32'h0000_8000, 32'hFFFD_0000, 32'h0000_0000);
        directed_set();
        for (int i = 0; i < 300; i++) add_vertex(rand_vertex());
        drain();

        set_scales(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        directed_set();
        for (int i = 0; i < 300; i++) add_vertex(rand_vertex());
        drain();

        set_scales(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        for (int i = 0; i < 200; i++) add_vertex(rand_vertex());
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            r = $urandom;
            set_scales($urandom_range(0, 8 * 65536) - 4 * 65536, $urandom, r);
            for (int i = 0; i < 150; i++) add_vertex(rand_vertex());
            drain();
        end

        quiet = 1'b1;
        set_scales(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        for (int i = 0; i < 200; i++) add_vertex(rand_vertex());
        drain();

        $display("Sent %0d vertices under unit, uniform and general scales including zero,",
                 n_in);
        $display("extreme and negative factors; %0d results checked, %0d with zero normal.",
                 n_out, n_zero);
        if (errors == 0 && vtx_expected.size() == 0) begin
            $display("PASS vertex_scale_normal_correct_top");
        end else begin
            $display("FAIL vertex_scale_normal_correct_top");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/vsnc_pkg.sv
rtl/vertex_scale_normal_correct_top.sv
tb/sv/tb_vertex_scale_normal_correct_top.sv
